@@ rtl/assert_macros.svh @@
// assertion helpers for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define A2RA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define A2RA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/a2ra_pkg.sv @@
package a2ra_pkg;

  localparam int INPUT_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;
  localparam int QF              = 30;
  localparam int SH              = QF - ANGLE_FRAC_BITS;

  localparam logic [63:0] K_ONE      = 64'd1073741824;
  localparam logic [63:0] K_SQRT3    = 64'd1859775393;
  localparam logic [63:0] K_2MS3     = 64'd287708255;
  localparam logic [63:0] K_PI_6     = 64'd562209904;
  localparam logic [63:0] K_PI_2     = 64'd1686629713;
  localparam logic [63:0] K_PI       = 64'd3373259426;
  localparam logic [63:0] K_A        = 64'd54663748;
  localparam logic [63:0] K_B        = 64'd505552562;
  localparam logic [63:0] K_C        = 64'd1516661121;
  localparam logic [63:0] K_EPS      = 64'd370728;
  localparam logic [63:0] ROUND_Q    = 64'd1 << (QF - 1);
  localparam logic [63:0] ROUND_OUT  = 64'd1 << (SH - 1);

  // divider widths used by all three divider instances: numerator, denominator, quotient widths
  localparam int DIV_N = 61;
  localparam int DIV_D = 32;
  localparam int DIV_Q = 31;

  // signed angle accumulator width
  localparam int V_W = 34;

  localparam logic [ANGLE_WIDTH-1:0] ANGLE_MAX =
    ANGLE_WIDTH'((K_PI + ROUND_OUT) >> SH);

  typedef struct packed {
    logic signed [INPUT_WIDTH-1:0] y_value;
    logic signed [INPUT_WIDTH-1:0] x_value;
  } in_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] angle;
    logic                          invalid;
  } out_t;

endpackage

@@ rtl/a2ra_div.sv @@
module a2ra_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [a2ra_pkg::DIV_N-1:0] num,
  input  logic [a2ra_pkg::DIV_D-1:0] den,
  output logic [a2ra_pkg::DIV_Q-1:0] quo
);
  import a2ra_pkg::*;

  logic [DIV_D-1:0] rem [DIV_Q];
  logic [DIV_D-1:0] dd  [DIV_Q];
  logic [DIV_Q-1:0] lo  [DIV_Q];
  logic [DIV_Q-1:0] qq  [DIV_Q];

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < DIV_Q; k++) begin : g_stage
    logic [DIV_D-1:0] r_in;
    logic [DIV_D-1:0] d_in;
    logic [DIV_Q-1:0] lo_in;
    logic [DIV_Q-1:0] q_in;
    logic [DIV_D:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in  = DIV_D'(num[DIV_N-1:DIV_Q]);
      assign d_in  = den;
      assign lo_in = num[DIV_Q-1:0];
      assign q_in  = '0;
    end else begin : g_next
      assign r_in  = rem[k-1];
      assign d_in  = dd[k-1];
      assign lo_in = lo[k-1];
      assign q_in  = qq[k-1];
    end

    assign trial = {r_in, lo_in[DIV_Q-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? DIV_D'(trial - {1'b0, d_in}) : trial[DIV_D-1:0];
        dd[k]  <= d_in;
        lo[k]  <= lo_in << 1;
        qq[k]  <= {q_in[DIV_Q-2:0], ge};
      end
    end
  end

  assign quo = qq[DIV_Q-1];

endmodule

@@ rtl/atan2_rational_approx_core.sv @@
// channel   direction  payload          handshake
// sample    in         y_value, x_value sample_valid / sample_stall
// result    out        angle, invalid   result_valid / result_stall
//
// one transaction per cycle in and out while sample_stall and result_stall are low;
// depth is set by three 31-stage divider pipelines plus multiplier stages
// rst clears all valid bits, including result_valid and the skid-full flag
// the whole pipeline holds only while the skid register is full
// sample_stall is the registered skid-full flag
module atan2_rational_approx_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  a2ra_pkg::in_t    sample,
  output logic             result_valid,
  input  logic             result_stall,
  output a2ra_pkg::out_t   result
);
  import a2ra_pkg::*;

  typedef struct packed {
    logic both_zero;
    logic x_zero;
    logic inv;
    logic xneg;
    logic yneg;
  } flags_t;

  typedef struct packed {
    flags_t      f;
    logic [28:0] t;
    logic        red;
    logic        numneg;
  } ctx2_t;

  typedef struct packed {
    flags_t      f;
    logic        red;
    logic [28:0] at;
    logic        tneg;
    logic        small_t;
  } ctx3_t;

  logic en;
  logic skid_valid;
  out_t skid_data;
  out_t res_next;
  logic arr;

  assign en           = !skid_valid;
  assign sample_stall = skid_valid;

  // capture
  logic                          p0_vld;
  logic signed [INPUT_WIDTH-1:0] p0_y;
  logic signed [INPUT_WIDTH-1:0] p0_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld <= 1'b0;
    end else if (en) begin
      p0_vld <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_y <= sample.y_value;
      p0_x <= sample.x_value;
    end
  end

  // ratio setup
  logic [INPUT_WIDTH-1:0] ay, ax, mn, mx;
  logic [DIV_N-1:0]       n1;
  logic [DIV_D-1:0]       d1;
  flags_t                 f0;

  always_comb begin
    ay = INPUT_WIDTH'(p0_y[INPUT_WIDTH-1] ? -p0_y : p0_y);
    ax = INPUT_WIDTH'(p0_x[INPUT_WIDTH-1] ? -p0_x : p0_x);
    f0.inv       = ay > ax;
    f0.both_zero = (ay == '0) && (ax == '0);
    f0.x_zero    = ax == '0;
    f0.xneg      = p0_x[INPUT_WIDTH-1];
    f0.yneg      = p0_y[INPUT_WIDTH-1];
    mn = f0.inv ? ax : ay;
    mx = f0.inv ? ay : ax;
    n1 = (DIV_N'(mn) << QF) + DIV_N'(mx >> 1);
    d1 = DIV_D'(mx);
  end

  logic [DIV_Q-1:0] q1;
  a2ra_div u_div1 (.clk(clk), .en(en), .num(n1), .den(d1), .quo(q1));

  flags_t           c1_line [DIV_Q];
  logic [DIV_Q-1:0] v1_line;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_line[0] <= f0;
      for (int k = 1; k < DIV_Q; k++) begin
        c1_line[k] <= c1_line[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1_line <= '0;
    end else if (en) begin
      v1_line <= {v1_line[DIV_Q-2:0], p0_vld};
    end
  end

  // range reduction product
  logic        pa_vld;
  flags_t      pa_f;
  logic [30:0] pa_t;
  logic        pa_red;
  logic [61:0] pa_ps;

  always_ff @(posedge clk) begin
    if (rst) begin
      pa_vld <= 1'b0;
    end else if (en) begin
      pa_vld <= v1_line[DIV_Q-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_f   <= c1_line[DIV_Q-1];
      pa_t   <= q1;
      pa_red <= q1 > 31'(K_2MS3);
      pa_ps  <= 62'(q1) * 62'(K_SQRT3);
    end
  end

  logic [31:0]        qs;
  logic signed [32:0] num2;
  logic               numneg;
  logic [29:0]        nm;
  logic [31:0]        den2;
  logic [DIV_N-1:0]   n2;
  ctx2_t              c2_in;

  always_comb begin
    qs     = 32'((pa_ps + 62'(ROUND_Q)) >> QF);
    num2   = $signed({1'b0, qs}) - $signed(33'(K_ONE));
    numneg = num2[32];
    nm     = 30'(numneg ? -num2 : num2);
    den2   = 32'(pa_t) + 32'(K_SQRT3);
    n2     = (DIV_N'(nm) << QF) + DIV_N'(den2 >> 1);
    c2_in.f      = pa_f;
    c2_in.t      = pa_t[28:0];
    c2_in.red    = pa_red;
    c2_in.numneg = numneg;
  end

  logic [DIV_Q-1:0] q2;
  a2ra_div u_div2 (.clk(clk), .en(en), .num(n2), .den(den2), .quo(q2));

  ctx2_t            c2_line [DIV_Q];
  logic [DIV_Q-1:0] v2_line;

  always_ff @(posedge clk) begin
    if (en) begin
      c2_line[0] <= c2_in;
      for (int k = 1; k < DIV_Q; k++) begin
        c2_line[k] <= c2_line[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2_line <= '0;
    end else if (en) begin
      v2_line <= {v2_line[DIV_Q-2:0], pa_vld};
    end
  end

  // correction polynomial
  ctx2_t       c2_out;
  logic [28:0] at_c;

  assign c2_out = c2_line[DIV_Q-1];
  assign at_c   = c2_out.red ? q2[28:0] : c2_out.t;

  logic        pc_vld, pd_vld, pe_vld, pf_vld, pg_vld;
  ctx3_t       pc_c, pd_c, pe_c, pf_c, pg_c;
  logic [57:0] pc_sq;
  logic [27:0] pd_s, pe_s, pf_s;
  logic [54:0] pe_ms;
  logic [56:0] pe_tr;
  logic [28:0] pf_m;
  logic [26:0] pf_tsq;
  logic [55:0] pg_prod;
  logic [30:0] pg_sc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_vld <= 1'b0;
      pd_vld <= 1'b0;
      pe_vld <= 1'b0;
      pf_vld <= 1'b0;
      pg_vld <= 1'b0;
    end else if (en) begin
      pc_vld <= v2_line[DIV_Q-1];
      pd_vld <= pc_vld;
      pe_vld <= pd_vld;
      pf_vld <= pe_vld;
      pg_vld <= pf_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_c.f       <= c2_out.f;
      pc_c.red     <= c2_out.red;
      pc_c.at      <= at_c;
      pc_c.tneg    <= c2_out.red && c2_out.numneg;
      pc_c.small_t <= 29'(K_EPS) > at_c;
      pc_sq        <= 58'(at_c) * 58'(at_c);

      pd_c <= pc_c;
      pd_s <= 28'((pc_sq + 58'(ROUND_Q)) >> QF);

      pe_c  <= pd_c;
      pe_s  <= pd_s;
      pe_ms <= 55'(pd_s) * 55'(K_A);
      pe_tr <= 57'(pd_c.at) * 57'(pd_s);

      pf_c   <= pe_c;
      pf_s   <= pe_s;
      pf_m   <= 29'(((pe_ms + 55'(ROUND_Q)) >> QF) + 55'(K_B));
      pf_tsq <= 27'((pe_tr + 57'(ROUND_Q)) >> QF);

      pg_c    <= pf_c;
      pg_prod <= 56'(pf_tsq) * 56'(pf_m);
      pg_sc   <= 31'(pf_s) + 31'(K_C);
    end
  end

  logic [DIV_N-1:0] n3;
  logic [DIV_D-1:0] d3;
  logic [DIV_Q-1:0] q3;

  assign n3 = DIV_N'(pg_prod) + DIV_N'(pg_sc >> 1);
  assign d3 = DIV_D'(pg_sc);

  a2ra_div u_div3 (.clk(clk), .en(en), .num(n3), .den(d3), .quo(q3));

  ctx3_t            c3_line [DIV_Q];
  logic [DIV_Q-1:0] v3_line;

  always_ff @(posedge clk) begin
    if (en) begin
      c3_line[0] <= pg_c;
      for (int k = 1; k < DIV_Q; k++) begin
        c3_line[k] <= c3_line[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3_line <= '0;
    end else if (en) begin
      v3_line <= {v3_line[DIV_Q-2:0], pg_vld};
    end
  end

  // angle assembly
  ctx3_t              c3_out;
  logic signed [V_W-1:0] ts, ts2, corr, vh_next;

  always_comb begin
    c3_out = c3_line[DIV_Q-1];
    corr   = $signed(V_W'(q3));
    ts     = c3_out.tneg ? -$signed(V_W'(c3_out.at)) : $signed(V_W'(c3_out.at));
    if (c3_out.small_t) begin
      ts2 = ts;
    end else if (c3_out.tneg) begin
      ts2 = ts + corr;
    end else begin
      ts2 = ts - corr;
    end
    vh_next = ts2 + (c3_out.red ? $signed(V_W'(K_PI_6)) : $signed(V_W'(0)));
    if (c3_out.f.x_zero) begin
      vh_next = $signed(V_W'(K_PI_2));
    end else if (c3_out.f.inv) begin
      vh_next = $signed(V_W'(K_PI_2)) - vh_next;
    end
  end

  logic                  ph_vld, pi_vld;
  flags_t                ph_f, pi_f;
  logic signed [V_W-1:0] ph_v, pi_v, v2n;

  always_comb begin
    v2n = ph_f.xneg ? $signed(V_W'(K_PI)) - ph_v : ph_v;
    v2n = ph_f.yneg ? -v2n : v2n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_vld <= 1'b0;
      pi_vld <= 1'b0;
    end else if (en) begin
      ph_vld <= v3_line[DIV_Q-1];
      pi_vld <= ph_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_f <= c3_out.f;
      ph_v <= vh_next;
      pi_f <= ph_f;
      pi_v <= v2n;
    end
  end

  // final rounding
  logic [V_W-1:0] mag, rmag;

  always_comb begin
    mag  = pi_v[V_W-1] ? V_W'(-pi_v) : V_W'(pi_v);
    rmag = (mag + V_W'(ROUND_OUT)) >> SH;
    if (pi_f.both_zero) begin
      res_next.angle   = '0;
      res_next.invalid = 1'b1;
    end else begin
      res_next.angle   = pi_v[V_W-1] ? ANGLE_WIDTH'(-rmag) : ANGLE_WIDTH'(rmag);
      res_next.invalid = 1'b0;
    end
  end

  assign arr = en && pi_vld;

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= arr;
      end
    end else if (arr) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      result <= skid_valid ? skid_data : res_next;
    end else if (arr) begin
      skid_data <= res_next;
    end
  end

endmodule

@@ rtl/a2ra_checker.sv @@
`include "assert_macros.svh"

module a2ra_checker (
  input logic           clk,
  input logic           rst,
  input logic           sample_stall,
  input logic           result_valid,
  input logic           result_stall,
  input a2ra_pkg::out_t result
);
  import a2ra_pkg::*;

  logic signed [ANGLE_WIDTH-1:0] amax;
  assign amax = $signed(ANGLE_MAX);

  `A2RA_ASSERT(a_invalid_zero, result_valid && result.invalid |-> result.angle == '0, "invalid with nonzero angle")
  `A2RA_ASSERT(a_angle_range, result_valid |-> result.angle <= amax && result.angle >= -amax, "angle beyond pi")
  `A2RA_ASSERT(a_held, result_valid && result_stall |=> result_valid && $stable(result), "stalled transaction changed")
  `A2RA_ASSERT(a_stall_cause, $rose(sample_stall) |-> $past(result_valid && result_stall), "input stall without output stall")
  `A2RA_ASSERT_ALWAYS(a_reset_idle, rst |=> !result_valid && !sample_stall, "activity right after reset")

endmodule

bind atan2_rational_approx_core a2ra_checker u_a2ra_checker (.*);
